[sv/clvt_pkg.sv]
// Package for the CAN last-value identifier table.
// Holds field widths, status codes and the controller/datapath structs.
// Depends on nothing; every other file but clvt_ram imports it.
`default_nettype none

package clvt_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int ID_W          = 29;
    localparam int DATA_W        = 8 * PAYLOAD_BYTES;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 5;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted word and restart the scan
        logic step;      // issue the next slot read
        logic commit;    // write the table and record the result
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // the compared slot ends the scan
        logic out_busy;  // the output register holds a word not yet taken
    } t_sts;

endpackage

`default_nettype wire

[sv/clvt_if.sv]
// Handshake interfaces for the input and result channels.
// Depends on clvt_pkg for the field widths.
`default_nettype none

interface clvt_in_if
    import clvt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] payload;

    modport source (output valid, output frame_id, output payload, input ready);
    modport sink   (input valid, input frame_id, input payload, output ready);
endinterface

interface clvt_out_if
    import clvt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[sv/can_last_value_id_table.sv]
// Top level of the CAN last-value identifier table.
// Depends on clvt_pkg, clvt_if, clvt_ctrl, clvt_dp and clvt_ram.
//
//   Channel   Direction  Word
//   i_in      in         frame_id (29 bits), payload (64 bits)
//   o_out     out        status (2 bits), slot (5 bits)
//
// One word is worked on at a time. A word whose scan stops at slot k is offered as a
// result word once the scan and commit are done, one identifier compared per cycle; the
// next input word is accepted only after that result has moved into the output register.
// Reset clears the valid bit of every slot at once, so the table is empty right after reset.
// The result waits in the output register; a new input word is accepted while it waits,
// and only the hand-off of the next result stalls on it.
`default_nettype none

module can_last_value_id_table
    import clvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clvt_in_if.sink     i_in,
    clvt_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;

    // The controller sequences accept, scan, commit and hand-off.
    clvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the slot stores and the output register.
    clvt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_frame_id  (i_in.frame_id),
        .i_payload   (i_in.payload),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_slot      (o_out.slot)
    );

endmodule

`default_nettype wire

[sv/clvt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module clvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/clvt_ctrl.sv]
// Controller of the identifier table: accept, scan, commit, hand off.
// Depends on clvt_pkg for the command and status structs.
`default_nettype none

module clvt_ctrl
    import clvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[sv/clvt_dp.sv]
// Datapath of the identifier table: slot stores, scan pointer, compare, result.
// Depends on clvt_pkg and on clvt_ram for the identifier and payload stores.
`default_nettype none

module clvt_dp
    import clvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [ID_W-1:0]     i_frame_id,
    input  wire logic [DATA_W-1:0]   i_payload,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [SLOT_W-1:0]   o_slot
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [ID_W-1:0]     r_id;
    logic [DATA_W-1:0]   r_data;
    logic [CW-1:0]       r_rd_addr;
    logic [AW-1:0]       r_cmp_addr;
    logic                r_cmp_vld;
    logic                r_valid [TABLE_DEPTH];
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic                rd_issue;
    logic [AW-1:0]       ram_rd_addr;
    logic [ID_W-1:0]     id_rd;
    logic [ID_W-1:0]     eff_id;
    logic                match;
    logic                empty;
    logic                last;
    logic                id_we;
    logic                data_we;

    // Reads stop once the pointer has passed the last slot.
    assign rd_issue    = r_rd_addr < CW'(TABLE_DEPTH);
    assign ram_rd_addr = rd_issue ? r_rd_addr[AW-1:0] : '0;

    // A slot never written since reset reads as empty.
    assign eff_id = r_valid[r_cmp_addr] ? id_rd : '0;
    assign match  = eff_id == r_id;
    assign empty  = eff_id == '0;
    assign last   = r_cmp_addr == AW'(TABLE_DEPTH - 1);

    assign o_sts.scan_done = r_cmp_vld && (match || empty || last);
    assign o_sts.out_busy  = o_out_valid && !i_out_ready;

    // A zero identifier matches an empty slot, so only its payload is written.
    assign data_we = i_cmd.commit && (match || empty);
    assign id_we   = i_cmd.commit && !match && empty;

    clvt_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_we      (id_we),
        .i_wr_addr (r_cmp_addr),
        .i_wr_data (r_id),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (id_rd)
    );

    clvt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_we      (data_we),
        .i_wr_addr (r_cmp_addr),
        .i_wr_data (r_data),
        .i_rd_addr (r_cmp_addr),
        .o_rd_data ()
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_frame_id;
            r_data <= i_payload;
        end
        if (i_cmd.step && rd_issue) begin
            r_cmp_addr <= r_rd_addr[AW-1:0];
        end
        if (i_cmd.commit) begin
            if (match) begin
                r_status <= STATUS_UPDATED;
                r_slot   <= SLOT_W'(r_cmp_addr);
            end else if (empty) begin
                r_status <= STATUS_INSERTED;
                r_slot   <= SLOT_W'(r_cmp_addr);
            end else begin
                r_status <= STATUS_DROPPED;
                r_slot   <= '0;
            end
        end
        if (i_cmd.out_load) begin
            o_status <= r_status;
            o_slot   <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr   <= '0;
            r_cmp_vld   <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (i_cmd.load) begin
                r_rd_addr <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.step) begin
                if (rd_issue) begin
                    r_rd_addr <= r_rd_addr + CW'(1);
                end
                r_cmp_vld <= rd_issue;
            end else if (i_cmd.commit) begin
                r_cmp_vld <= 1'b0;
            end
            if (id_we) begin
                r_valid[r_cmp_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
